/* hw/rtl/tshp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper package
// Shared register indexes, widths, reset values and controller commands.
// ----------------------------------------------------------------------------
package tshp_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 24;
    localparam int ENV_FRAC_BITS_DEF = 8;

    localparam int COEFF_W = 17;
    localparam int GAIN_W  = 24;
    localparam int THR_W   = 16;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_FAST_ATT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FAST_REL  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLOW_ATT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLOW_REL  = 3'd3;
    localparam logic [IDX_W-1:0] REG_ATT_GAIN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SUS_GAIN  = 3'd5;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPAN_RECIP = 3'd7;

    localparam logic [COEFF_W-1:0] RST_FAST_ATT  = 17'd2234;
    localparam logic [COEFF_W-1:0] RST_FAST_REL  = 17'd372;
    localparam logic [COEFF_W-1:0] RST_SLOW_ATT  = 17'd30;
    localparam logic [COEFF_W-1:0] RST_SLOW_REL  = 17'd9;
    localparam logic [GAIN_W-1:0]  RST_ATT_GAIN  = 24'd130762;
    localparam logic [GAIN_W-1:0]  RST_SUS_GAIN  = 24'd65536;
    localparam logic [THR_W-1:0]   RST_THRESHOLD = 16'd360;
    localparam logic [GAIN_W-1:0]  RST_SPAN_RECIP = 24'd66199;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ENV,
        CMD_DIV_START,
        CMD_DIV_STEP,
        CMD_T,
        CMD_T2,
        CMD_S,
        CMD_GAIN,
        CMD_PROD,
        CMD_OUT
    } tshp_cmd_t;

    typedef struct packed {
        tshp_cmd_t cmd;
    } tshp_ctrl_t;

    typedef struct packed {
        logic div_done;
    } tshp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/tshp_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper datapath
// Envelopes, configuration registers, serial divider and shared arithmetic.
// ----------------------------------------------------------------------------
module tshp_datapath
    import tshp_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int ENV_FRAC_BITS = ENV_FRAC_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire tshp_ctrl_t              ctrl,
    output tshp_stat_t                   stat,
    input  wire logic                    cfg_we,
    input  wire logic [IDX_W-1:0]        cfg_idx,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic [SAMPLE_WIDTH-1:0] sample_in,
    output logic [SAMPLE_WIDTH-1:0]      sample_out,
    output logic [SAMPLE_WIDTH-2:0]      transient_level,
    output logic                         detected
);

    localparam int MAG_W = SAMPLE_WIDTH;
    localparam int ENV_W = SAMPLE_WIDTH + ENV_FRAC_BITS;
    localparam int NUM_W = ENV_W + 16;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [MAG_W-1:0] POS_MAX = {1'b0, {(MAG_W-1){1'b1}}};
    localparam logic [MAG_W-1:0] NEG_MAX = {1'b1, {(MAG_W-1){1'b0}}};

    logic [COEFF_W-1:0] fa_reg, fr_reg, sa_reg, sr_reg;
    logic [GAIN_W-1:0]  ag_reg, sg_reg, sp_reg;
    logic [THR_W-1:0]   th_reg;

    logic               neg_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [ENV_W-1:0]   fast_reg, slow_reg;
    logic [ENV_W-1:0]   tr_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [ENV_W:0]     rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [16:0]        t_reg;
    logic [16:0]        t2_reg;
    logic [16:0]        s_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [MAG_W+GAIN_W-17:0] prod_reg;

    function automatic logic [COEFF_W-1:0] clampc(input logic [COEFF_W-1:0] c);
        return (c > 17'd65536) ? 17'd65536 : c;
    endfunction

    function automatic logic [ENV_W-1:0] track(input logic [ENV_W-1:0] env,
                                               input logic [ENV_W-1:0] a,
                                               input logic [COEFF_W-1:0] ca,
                                               input logic [COEFF_W-1:0] cr);
        logic [ENV_W+COEFF_W-1:0] p;
        if (a > env)
        begin
            p = clampc(ca) * (a - env);
            return env + ENV_W'(p >> 16);
        end
        p = clampc(cr) * (env - a);
        return env - ENV_W'(p >> 16);
    endfunction

    logic [ENV_W-1:0] a_val;
    logic [ENV_W-1:0] den;
    logic [ENV_W:0]   rem_sh;
    logic             q_bit;
    logic [NUM_W-1:0] num_bits;
    logic [NUM_W:0]   d_full;
    logic [32:0]      d_sat;
    logic [57:0]      t_prod;
    logic [33:0]      t2_prod;
    logic [17:0]      poly;
    logic [34:0]      s_prod;
    logic [GAIN_W-1:0] gdiff;
    logic [GAIN_W+16:0] g_prod;
    logic [MAG_W+GAIN_W-1:0] m_prod;
    logic [MAG_W+GAIN_W-17:0] p_sat;
    logic [ENV_W-1:0] lvl_full;

    assign a_val    = ENV_W'(mag_reg) << ENV_FRAC_BITS;
    assign den      = (slow_reg == '0) ? ENV_W'(1) : slow_reg;
    assign num_bits = {tr_reg, 16'd0};
    assign rem_sh   = {rem_reg[ENV_W-1:0], num_bits[cnt_reg - 1'b1]};
    assign q_bit    = rem_sh >= {1'b0, den};
    assign d_full   = {1'b0, quo_reg} - (NUM_W+1)'(th_reg);
    assign d_sat    = (d_full > (NUM_W+1)'(64'h1_0000_0000)) ? 33'h1_0000_0000
                                                            : 33'(d_full);
    assign t_prod   = 58'(d_sat) * 58'(sp_reg);
    assign t2_prod  = t_reg * t_reg;
    assign poly     = 18'd196608 - {t_reg, 1'b0};
    assign s_prod   = t2_reg * poly;
    assign gdiff    = (ag_reg >= sg_reg) ? ag_reg - sg_reg : sg_reg - ag_reg;
    assign g_prod   = s_reg * gdiff;
    assign m_prod   = mag_reg * gain_reg;
    assign p_sat    = m_prod[MAG_W+GAIN_W-1:16];
    assign lvl_full = tr_reg >> ENV_FRAC_BITS;

    assign stat.div_done = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_reg   <= RST_FAST_ATT;
            fr_reg   <= RST_FAST_REL;
            sa_reg   <= RST_SLOW_ATT;
            sr_reg   <= RST_SLOW_REL;
            ag_reg   <= RST_ATT_GAIN;
            sg_reg   <= RST_SUS_GAIN;
            th_reg   <= RST_THRESHOLD;
            sp_reg   <= RST_SPAN_RECIP;
            fast_reg <= '0;
            slow_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_FAST_ATT:   fa_reg <= cfg_data[COEFF_W-1:0];
                    REG_FAST_REL:   fr_reg <= cfg_data[COEFF_W-1:0];
                    REG_SLOW_ATT:   sa_reg <= cfg_data[COEFF_W-1:0];
                    REG_SLOW_REL:   sr_reg <= cfg_data[COEFF_W-1:0];
                    REG_ATT_GAIN:   ag_reg <= cfg_data;
                    REG_SUS_GAIN:   sg_reg <= cfg_data;
                    REG_THRESHOLD:  th_reg <= cfg_data[THR_W-1:0];
                    REG_SPAN_RECIP: sp_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (ctrl.cmd)
                CMD_ENV:
                begin
                    fast_reg <= track(fast_reg, a_val, fa_reg, fr_reg);
                    slow_reg <= track(slow_reg, a_val, sa_reg, sr_reg);
                end
                CMD_DIV_START: cnt_reg <= CNT_W'(NUM_W);
                CMD_DIV_STEP:  cnt_reg <= cnt_reg - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            CMD_LOAD:
            begin
                neg_reg <= sample_in[SAMPLE_WIDTH-1];
                mag_reg <= sample_in[SAMPLE_WIDTH-1] ? MAG_W'(-sample_in) : sample_in;
            end
            CMD_DIV_START:
            begin
                tr_reg  <= (fast_reg > slow_reg) ? fast_reg - slow_reg : '0;
                quo_reg <= '0;
                rem_reg <= '0;
            end
            CMD_DIV_STEP:
            begin
                quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
                rem_reg <= q_bit ? rem_sh - {1'b0, den} : rem_sh;
            end
            CMD_T:
            begin
                if ({1'b0, quo_reg} > (NUM_W+1)'(th_reg))
                    t_reg <= (t_prod[57:16] > 42'd65536) ? 17'd65536 : t_prod[32:16];
                else
                    t_reg <= '0;
            end
            CMD_T2: t2_reg <= t2_prod[32:16];
            CMD_S:  s_reg  <= s_prod[32:16];
            CMD_GAIN:
                gain_reg <= (ag_reg >= sg_reg) ? sg_reg + GAIN_W'(g_prod >> 16)
                                               : sg_reg - GAIN_W'(g_prod >> 16);
            CMD_PROD: prod_reg <= p_sat;
            CMD_OUT:
            begin
                if (neg_reg)
                    sample_out <= (prod_reg > (MAG_W+GAIN_W-16)'(NEG_MAX)) ? NEG_MAX
                                  : MAG_W'(-prod_reg);
                else
                    sample_out <= (prod_reg > (MAG_W+GAIN_W-16)'(POS_MAX)) ? POS_MAX
                                  : MAG_W'(prod_reg);
                transient_level <= (lvl_full > ENV_W'(POS_MAX)) ? POS_MAX[MAG_W-2:0]
                                   : lvl_full[MAG_W-2:0];
                detected <= s_reg > 17'd32768;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/tshp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper controller
// Sequences one word through the datapath and runs the output handshake.
// ----------------------------------------------------------------------------
module tshp_ctrl
    import tshp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output tshp_ctrl_t      ctrl,
    input  wire tshp_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ENV, ST_DSTART, ST_DIV, ST_T, ST_T2, ST_S,
        ST_GAIN, ST_PROD, ST_OUT, ST_HOLD
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == ST_IDLE) ||
                       (state_reg == ST_HOLD && out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctrl.cmd = CMD_NONE;
        case (state_reg)
            ST_IDLE:   ctrl.cmd = in_valid ? CMD_LOAD : CMD_NONE;
            ST_HOLD:   ctrl.cmd = (in_valid && out_ready) ? CMD_LOAD : CMD_NONE;
            ST_ENV:    ctrl.cmd = CMD_ENV;
            ST_DSTART: ctrl.cmd = CMD_DIV_START;
            ST_DIV:    ctrl.cmd = stat.div_done ? CMD_NONE : CMD_DIV_STEP;
            ST_T:      ctrl.cmd = CMD_T;
            ST_T2:     ctrl.cmd = CMD_T2;
            ST_S:      ctrl.cmd = CMD_S;
            ST_GAIN:   ctrl.cmd = CMD_GAIN;
            ST_PROD:   ctrl.cmd = CMD_PROD;
            ST_OUT:    ctrl.cmd = CMD_OUT;
            default:   ctrl.cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:   if (in_valid) state_reg <= ST_ENV;
                ST_ENV:    state_reg <= ST_DSTART;
                ST_DSTART: state_reg <= ST_DIV;
                ST_DIV:    if (stat.div_done) state_reg <= ST_T;
                ST_T:      state_reg <= ST_T2;
                ST_T2:     state_reg <= ST_S;
                ST_S:      state_reg <= ST_GAIN;
                ST_GAIN:   state_reg <= ST_PROD;
                ST_PROD:   state_reg <= ST_OUT;
                ST_OUT:
                begin
                    state_reg     <= ST_HOLD;
                    out_valid_reg <= 1'b1;
                end
                ST_HOLD:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= in_valid ? ST_ENV : ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/transient_shaper_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper top level
// Dual-envelope transient shaper with a stream input, stream output and
// a register write channel.
// ----------------------------------------------------------------------------
// Each word passes through a bit-serial divider that normalizes the
// transient level by the slow envelope. The next word is accepted in the
// cycle its predecessor's result is taken. Registers are to be written
// only while the block is idle; the block itself does not enforce this.
module transient_shaper_top
    import tshp_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int ENV_FRAC_BITS = ENV_FRAC_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [SAMPLE_WIDTH-1:0] s_axis_tdata,   // sample_in
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [2*SAMPLE_WIDTH-1:0]    m_axis_tdata,   // sample_out, transient_level, detected
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    tshp_ctrl_t                ctrl;
    tshp_stat_t                stat;
    logic [SAMPLE_WIDTH-1:0]   sample_out;
    logic [SAMPLE_WIDTH-2:0]   transient_level;
    logic                      detected;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {detected, transient_level, sample_out};

    tshp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    tshp_datapath #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .ENV_FRAC_BITS (ENV_FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .cfg_we          (cfg_valid),
        .cfg_idx         (cfg_index),
        .cfg_data        (cfg_data),
        .sample_in       (s_axis_tdata),
        .sample_out      (sample_out),
        .transient_level (transient_level),
        .detected        (detected)
    );

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transient shaper testbench
// Streams audio words through the shaper under random idling on both sides
// and compares every result word with a bit-exact envelope and gain predictor
// kept in the testbench. Register settings are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import tshp_pkg::*;

    typedef struct packed {
        logic        detected;
        logic [22:0] level;
        logic [23:0] sample;
    } shaped_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;   // sample_in
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;        // sample_out, transient_level, detected
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    longint unsigned   fast_att, fast_rel, slow_att, slow_rel;
    longint unsigned   att_gain, sus_gain, threshold, span_recip;
    longint unsigned   fast_env, slow_env;
    shaped_t           shaped_q[$];
    int                errors = 0;
    int                hold_cycles = 0;
    bit                idle_on = 1'b1;

    always #1 clk = ~clk;

    transient_shaper_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic longint unsigned env_step(longint unsigned env, longint unsigned a,
                                                 longint unsigned ca, longint unsigned cr);
        longint unsigned c;
        if (a > env)
        begin
            c = (ca > 65536) ? 65536 : ca;
            return env + ((c * (a - env)) >> 16);
        end
        c = (cr > 65536) ? 65536 : cr;
        return env - ((c * (env - a)) >> 16);
    endfunction

    function automatic shaped_t shape_sample(logic [23:0] x);
        logic            neg;
        longint unsigned mag, tr, den, norm, d, t, t2, s, gain, prod, lvl;
        shaped_t         r;
        neg = x[23];
        mag = neg ? (64'd16777216 - longint'(x)) : longint'(x);
        fast_env = env_step(fast_env, mag << 8, fast_att, fast_rel);
        slow_env = env_step(slow_env, mag << 8, slow_att, slow_rel);
        tr = (fast_env > slow_env) ? fast_env - slow_env : 0;
        den = (slow_env != 0) ? slow_env : 1;
        norm = (tr << 16) / den;
        s = 0;
        if (norm > threshold)
        begin
            d = norm - threshold;
            if (d > 64'h1_0000_0000)
                d = 64'h1_0000_0000;
            t = (d * span_recip) >> 16;
            if (t > 65536)
                t = 65536;
            t2 = (t * t) >> 16;
            s = (t2 * (196608 - 2 * t)) >> 16;
        end
        if (att_gain >= sus_gain)
            gain = sus_gain + ((s * (att_gain - sus_gain)) >> 16);
        else
            gain = sus_gain - ((s * (sus_gain - att_gain)) >> 16);
        prod = (mag * gain) >> 16;
        if (neg)
        begin
            if (prod > 8388608)
                prod = 8388608;
            r.sample = 24'(64'd16777216 - prod);
        end
        else
        begin
            if (prod > 8388607)
                prod = 8388607;
            r.sample = 24'(prod);
        end
        lvl = tr >> 8;
        if (lvl > 8388607)
            lvl = 8388607;
        r.level = 23'(lvl);
        r.detected = (s > 32768);
        return r;
    endfunction

    task automatic send_sample(logic [23:0] x);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 32)
            @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do
            @(posedge clk);
        while (!s_axis_tready);
        shaped_q.push_back(shape_sample(x));
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (shaped_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_FAST_ATT:   fast_att   = val & 24'h1FFFF;
            REG_FAST_REL:   fast_rel   = val & 24'h1FFFF;
            REG_SLOW_ATT:   slow_att   = val & 24'h1FFFF;
            REG_SLOW_REL:   slow_rel   = val & 24'h1FFFF;
            REG_ATT_GAIN:   att_gain   = val;
            REG_SUS_GAIN:   sus_gain   = val;
            REG_THRESHOLD:  threshold  = val & 24'hFFFF;
            REG_SPAN_RECIP: span_recip = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(int fa, int fr, int sa, int sr, int ag, int sg, int th, int sp);
        wait_drain();
        write_reg(REG_FAST_ATT, CFG_W'(fa));
        write_reg(REG_FAST_REL, CFG_W'(fr));
        write_reg(REG_SLOW_ATT, CFG_W'(sa));
        write_reg(REG_SLOW_REL, CFG_W'(sr));
        write_reg(REG_ATT_GAIN, CFG_W'(ag));
        write_reg(REG_SUS_GAIN, CFG_W'(sg));
        write_reg(REG_THRESHOLD, CFG_W'(th));
        write_reg(REG_SPAN_RECIP, CFG_W'(sp));
    endtask

    function automatic logic [23:0] pick_sample(int kind);
        case (kind)
            0: return 24'($urandom);
            1: return 24'($urandom_range(255)) ^ ({24{1'($urandom_range(1))}});
            2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed(24'($urandom_range(8388607, 4000000)))
                            * ($urandom_range(1) ? 1 : -1));
        endcase
    endfunction

    task automatic test_directed();
        logic [23:0] edge_vals[8];
        edge_vals = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF,
                      24'h800000, 24'h000000, 24'h400000, 24'hC00000};
        foreach (edge_vals[i])
            send_sample(edge_vals[i]);
        // hold the slow envelope where it is, jump the fast one to full scale
        load_regs(65536, 131071, 0, 0, 24'hFFFFFF, 0, 0, 24'hFFFFFF);
        send_sample(24'h800000);
        send_sample(24'h7FFFFF);
        send_sample(24'h000005);
        // zero span reciprocal, huge sustain gain to saturate
        load_regs(131071, 65536, 65536, 0, 0, 24'hFFFFFF, 65535, 0);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h000100);
        send_sample(24'hFFFF00);
    endtask

    task automatic test_random(int n);
        int left;
        int quiet;
        left = n;
        while (left > 0)
        begin
            quiet = $urandom_range(12, 2);
            repeat (quiet) send_sample(pick_sample(1));
            repeat ($urandom_range(4, 1)) send_sample(pick_sample($urandom_range(3)));
            left -= quiet + 2;
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 2000;
        repeat (8) send_sample(pick_sample($urandom_range(3)));
    endtask

    task automatic test_pause();
        repeat (10) send_sample(pick_sample($urandom_range(3)));
        wait_drain();
        repeat (10) send_sample(pick_sample($urandom_range(3)));
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !(idle_on && $urandom_range(99) < 32);
        end
    end

    always @(posedge clk)
    begin
        shaped_t got;
        shaped_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (shaped_q.size() == 0)
            begin
                $error("result word with nothing expected: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = shaped_q.pop_front();
                if (got.sample !== want.sample)
                begin
                    $error("sample_out expected %h actual %h", want.sample, got.sample);
                    errors++;
                end
                if (got.level !== want.level)
                begin
                    $error("transient_level expected %h actual %h", want.level, got.level);
                    errors++;
                end
                if (got.detected !== want.detected)
                begin
                    $error("detected expected %b actual %b", want.detected, got.detected);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        fast_att = RST_FAST_ATT;   fast_rel = RST_FAST_REL;
        slow_att = RST_SLOW_ATT;   slow_rel = RST_SLOW_REL;
        att_gain = RST_ATT_GAIN;   sus_gain = RST_SUS_GAIN;
        threshold = RST_THRESHOLD; span_recip = RST_SPAN_RECIP;
        fast_env = 0;
        slow_env = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_random(60);
        test_directed();
        load_regs(2234, 372, 30, 9, 130762, 65536, 360, 66199);
        test_random(80);
        load_regs(30000, 8000, 3000, 500, 24'hFFFFFF, 4096, 100, 24'h020000);
        test_backpressure();
        test_random(60);
        idle_on = 1'b0;
        load_regs($urandom_range(131071), $urandom_range(131071), $urandom_range(8000),
                  $urandom_range(2000), $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                  $urandom_range(65535), $urandom_range(24'hFFFFFF));
        test_random(60);
        idle_on = 1'b1;
        load_regs(65536, 65536, 100, 100, 16384, 200000, 32768, 131072);
        test_pause();
        test_random(60);
        load_regs(0, 0, 0, 0, 0, 0, 65535, 24'hFFFFFF);
        test_random(20);
        load_regs(10000, 2000, 300, 50, 300000, 40000, 0, 65536);
        test_random(60);
        wait_drain();
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
